// ===== src/cmap_pkg.sv =====
package cmap_pkg;

	// Size of the color index range and of the anchor list.
	localparam int INDEX_LEVELS = 256;
	localparam int MAX_ANCHORS = 6;

	localparam int IDX_W = $clog2(INDEX_LEVELS);
	localparam int LAST = INDEX_LEVELS - 1;
	localparam int ANC_W = 3;
	localparam int VAL_W = 32;
	localparam int DIFF_W = VAL_W + 1;
	localparam int DEN2_W = VAL_W + 1;
	localparam int NUM_W = VAL_W + 2 + IDX_W;
	localparam int P_W = IDX_W + ANC_W;
	localparam int Y_W = 8 + IDX_W;
	localparam int HALF = LAST / 2;
	localparam longint unsigned RECIP = (64'd1 << Y_W) / LAST;

	typedef enum logic [2:0] {
		REG_RANGE_LOW,
		REG_RANGE_HIGH,
		REG_ANCHOR_COUNT,
		REG_PAIR_A,
		REG_PAIR_B,
		REG_PAIR_C
	} cmap_reg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] range_low;
		logic signed [VAL_W-1:0] range_high;
		logic [ANC_W-1:0] anchor_count;
		logic [47:0] pair_a;
		logic [47:0] pair_b;
		logic [47:0] pair_c;
	} cmap_cfg_t;

	typedef struct packed {
		logic vld;
		logic ok;
		logic [IDX_W-1:0] idx;
	} cmap_idx_t;

	typedef struct packed {
		logic vld;
		logic [31:0] data;
	} cmap_pix_t;

	function automatic logic [23:0] anchor_rgb(cmap_cfg_t cfg, logic [ANC_W-1:0] k);
		logic [47:0] pr;
		case (k[ANC_W-1:1])
			2'd0: pr = cfg.pair_a;
			2'd1: pr = cfg.pair_b;
			default: pr = cfg.pair_c;
		endcase
		return k[0] ? pr[47:24] : pr[23:0];
	endfunction

endpackage

// ===== src/cmap_cfg.sv =====
module cmap_cfg import cmap_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_data,
	output cmap_cfg_t cfg
);

	cmap_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low <= '0;
			cfg_q.range_high <= VAL_W'(65536);
			cfg_q.anchor_count <= ANC_W'(2);
			cfg_q.pair_a <= 48'hFFFFFF000000;
			cfg_q.pair_b <= '0;
			cfg_q.pair_c <= '0;
		end else if (cfg_valid) begin
			case (cmap_reg_t'(cfg_index))
				REG_RANGE_LOW: cfg_q.range_low <= cfg_data[VAL_W-1:0];
				REG_RANGE_HIGH: cfg_q.range_high <= cfg_data[VAL_W-1:0];
				REG_ANCHOR_COUNT: cfg_q.anchor_count <= cfg_data[ANC_W-1:0];
				REG_PAIR_A: cfg_q.pair_a <= cfg_data;
				REG_PAIR_B: cfg_q.pair_b <= cfg_data;
				REG_PAIR_C: cfg_q.pair_c <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/cmap_index.sv =====
module cmap_index import cmap_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pipe_en,
	input logic in_valid,
	input logic signed [VAL_W-1:0] sample_value,
	input logic sample_finite,
	input cmap_cfg_t cfg,
	output cmap_idx_t idx_out
);

	logic v_s1, v_s2, v_s3;
	logic ok_s1, ok_s2, ok_s3;
	logic pos_s2, pos_s3;
	logic signed [DIFF_W-1:0] diff_s1, den_s1;
	logic [NUM_W-1:0] n_s2, rem_s3;
	logic [DEN2_W-1:0] d2_s2, d2_s3;
	logic ovf_s3;
	logic [NUM_W-1:0] num_prod;

	// Quotient bit stages, most significant bit first.
	logic bv_s4 [IDX_W];
	logic bok_s4 [IDX_W];
	logic bpos_s4 [IDX_W];
	logic bovf_s4 [IDX_W];
	logic [NUM_W-1:0] brem_s4 [IDX_W];
	logic [IDX_W-1:0] bq_s4 [IDX_W];
	logic [DEN2_W-1:0] bd2_s4 [IDX_W];

	logic src_v [IDX_W];
	logic src_ok [IDX_W];
	logic src_pos [IDX_W];
	logic src_ovf [IDX_W];
	logic [NUM_W-1:0] src_rem [IDX_W];
	logic [IDX_W-1:0] src_q [IDX_W];
	logic [DEN2_W-1:0] src_d2 [IDX_W];

	logic [IDX_W-1:0] q_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign num_prod = NUM_W'(diff_s1[VAL_W-1:0]) * NUM_W'(LAST);

	// The rounded index is floor((2*(v-low)*L + den) / (2*den)).
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			diff_s1 <= DIFF_W'(sample_value) - DIFF_W'(cfg.range_low);
			den_s1 <= DIFF_W'(cfg.range_high) - DIFF_W'(cfg.range_low);
			ok_s1 <= sample_finite && (cfg.range_high > cfg.range_low);

			ok_s2 <= ok_s1;
			pos_s2 <= ok_s1 && (diff_s1 > 0);
			n_s2 <= (num_prod << 1) + NUM_W'(den_s1[VAL_W-1:0]);
			d2_s2 <= {den_s1[VAL_W-1:0], 1'b0};

			ok_s3 <= ok_s2;
			pos_s3 <= pos_s2;
			rem_s3 <= n_s2;
			d2_s3 <= d2_s2;
			ovf_s3 <= n_s2 >= (NUM_W'(d2_s2) << IDX_W);
		end
	end

	for (genvar k = 0; k < IDX_W; k++) begin : g_bit
		localparam int B = IDX_W - 1 - k;
		logic [NUM_W-1:0] trial;

		if (k == 0) begin : g_first
			assign src_v[k] = v_s3;
			assign src_ok[k] = ok_s3;
			assign src_pos[k] = pos_s3;
			assign src_ovf[k] = ovf_s3;
			assign src_rem[k] = rem_s3;
			assign src_q[k] = '0;
			assign src_d2[k] = d2_s3;
		end else begin : g_next
			assign src_v[k] = bv_s4[k-1];
			assign src_ok[k] = bok_s4[k-1];
			assign src_pos[k] = bpos_s4[k-1];
			assign src_ovf[k] = bovf_s4[k-1];
			assign src_rem[k] = brem_s4[k-1];
			assign src_q[k] = bq_s4[k-1];
			assign src_d2[k] = bd2_s4[k-1];
		end

		assign trial = NUM_W'(src_d2[k]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bv_s4[k] <= 1'b0;
			end else if (pipe_en) begin
				bv_s4[k] <= src_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				bok_s4[k] <= src_ok[k];
				bpos_s4[k] <= src_pos[k];
				bovf_s4[k] <= src_ovf[k];
				bd2_s4[k] <= src_d2[k];
				if (src_rem[k] >= trial) begin
					brem_s4[k] <= src_rem[k] - trial;
					bq_s4[k] <= src_q[k] | (IDX_W'(1) << B);
				end else begin
					brem_s4[k] <= src_rem[k];
					bq_s4[k] <= src_q[k];
				end
			end
		end
	end

	assign q_fin = bq_s4[IDX_W-1];

	always_comb begin
		idx_out.vld = bv_s4[IDX_W-1];
		idx_out.ok = bok_s4[IDX_W-1];
		if (!bpos_s4[IDX_W-1]) begin
			idx_out.idx = '0;
		end else if (bovf_s4[IDX_W-1] || (q_fin > IDX_W'(LAST))) begin
			idx_out.idx = IDX_W'(LAST);
		end else begin
			idx_out.idx = q_fin;
		end
	end

endmodule

// ===== src/cmap_blend.sv =====
module cmap_blend import cmap_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pipe_en,
	input cmap_idx_t idx_in,
	input cmap_cfg_t cfg,
	output cmap_pix_t pix_out
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6;
	logic [P_W-1:0] p_s1;
	logic [ANC_W-1:0] nm1_s1;
	logic [ANC_W-1:0] left_s2, right_s2;
	logic [IDX_W-1:0] r_s2;
	logic [Y_W-1:0] y_s3 [3];
	logic [Y_W-1:0] y_s4 [3];
	logic [2*Y_W-1:0] prod_s4 [3];
	logic [7:0] qe_s5 [3];
	logic [Y_W-1:0] rem_s5 [3];
	logic [7:0] ch_s6 [3];

	logic [ANC_W-1:0] n_eff, nm1, left_c;
	logic [IDX_W-1:0] r_c;
	logic [23:0] lc, rc;
	logic [Y_W-1:0] y_c [3];
	logic [IDX_W-1:0] wlo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= idx_in.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		if (cfg.anchor_count == '0) begin
			n_eff = ANC_W'(1);
		end else if (cfg.anchor_count > ANC_W'(MAX_ANCHORS)) begin
			n_eff = ANC_W'(MAX_ANCHORS);
		end else begin
			n_eff = cfg.anchor_count;
		end
		nm1 = n_eff - ANC_W'(1);
	end

	// Segment number and offset within it, against constant multiples of L.
	always_comb begin
		left_c = '0;
		r_c = IDX_W'(p_s1);
		for (int k = 1; k < MAX_ANCHORS; k++) begin
			if (p_s1 >= P_W'(k * LAST)) begin
				left_c = ANC_W'(k);
				r_c = IDX_W'(p_s1 - P_W'(k * LAST));
			end
		end
	end

	assign lc = anchor_rgb(cfg, left_s2);
	assign rc = anchor_rgb(cfg, right_s2);
	assign wlo = IDX_W'(LAST) - r_s2;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			y_c[c] = Y_W'(lc[16-8*c +: 8]) * Y_W'(wlo) + Y_W'(rc[16-8*c +: 8]) * Y_W'(r_s2)
				+ Y_W'(HALF);
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ok_s1 <= idx_in.ok;
			nm1_s1 <= nm1;
			p_s1 <= P_W'(idx_in.idx) * P_W'(nm1);

			ok_s2 <= ok_s1;
			left_s2 <= left_c;
			right_s2 <= (left_c == nm1_s1) ? left_c : left_c + ANC_W'(1);
			r_s2 <= r_c;

			ok_s3 <= ok_s2;
			ok_s4 <= ok_s3;
			ok_s5 <= ok_s4;
			ok_s6 <= ok_s5;
			for (int c = 0; c < 3; c++) begin
				y_s3[c] <= y_c[c];
				y_s4[c] <= y_s3[c];
				prod_s4[c] <= (2*Y_W)'(y_s3[c]) * (2*Y_W)'(RECIP);
				// The reciprocal estimate is low by at most one.
				qe_s5[c] <= prod_s4[c][Y_W +: 8];
				rem_s5[c] <= y_s4[c] - Y_W'(prod_s4[c][Y_W +: 8]) * Y_W'(LAST);
				ch_s6[c] <= (rem_s5[c] >= Y_W'(LAST)) ? qe_s5[c] + 8'd1 : qe_s5[c];
			end
		end
	end

	assign pix_out.vld = v_s6;
	assign pix_out.data = ok_s6 ? {8'hFF, ch_s6[2], ch_s6[1], ch_s6[0]} : 32'd0;

endmodule

// ===== src/cmap_outq.sv =====
module cmap_outq import cmap_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmap_pix_t pix_in,
	output logic pipe_en,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata
);

	logic out_v_q, skid_v_q;
	logic [31:0] out_d_q, skid_d_q;

	// The pipeline moves whenever the spare slot is free, so an item that
	// leaves the last stage always has somewhere to go.
	assign pipe_en = !skid_v_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_axis_tready) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || m_axis_tready) begin
			out_v_q <= pix_in.vld;
		end else if (pix_in.vld) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_axis_tready) begin
				out_d_q <= skid_d_q;
			end
		end else if (!out_v_q || m_axis_tready) begin
			out_d_q <= pix_in.data;
		end else begin
			skid_d_q <= pix_in.data;
		end
	end

endmodule

// ===== src/scalar_to_color_map.sv =====
// Maps a stream of signed Q16.16 samples to RGBA pixels through a linear
// colormap of INDEX_LEVELS entries built from up to six anchor colors. One
// item is accepted per clock while s_axis_tready is high. Each result passes
// through the scaling divider, which resolves one index bit per stage,
// then six blending stages and the output register. A spare slot behind
// the output register lets the input keep flowing for one more item while
// a result waits. Non-finite samples, and all samples while range_high is
// not above range_low, give transparent black. The user must write the
// configuration registers only while no item is in flight; the block
// itself does not enforce this.
module scalar_to_color_map import cmap_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [31:0] s_axis_tdata, // [31:0] sample_value
	input logic s_axis_tuser, // [0] sample_finite
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_data
);

	cmap_cfg_t cfg;
	cmap_idx_t idx_bus;
	cmap_pix_t pix_bus;
	logic pipe_en;

	assign s_axis_tready = pipe_en;

	cmap_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	cmap_index u_index (
		.clk(clk),
		.arst_n(arst_n),
		.pipe_en(pipe_en),
		.in_valid(s_axis_tvalid),
		.sample_value(s_axis_tdata),
		.sample_finite(s_axis_tuser),
		.cfg(cfg),
		.idx_out(idx_bus)
	);

	cmap_blend u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.pipe_en(pipe_en),
		.idx_in(idx_bus),
		.cfg(cfg),
		.pix_out(pix_bus)
	);

	cmap_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_bus),
		.pipe_en(pipe_en),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

endmodule

// ===== src/cmap_checker.sv =====
module cmap_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output item changed while stalled");

	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:24] == 8'hFF || m_axis_tdata[31:24] == 8'h00))
		else $error("alpha is neither opaque nor transparent");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[31:24] == 8'h00) |-> m_axis_tdata[23:0] == 24'd0)
		else $error("transparent pixel carries color");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with no result waiting");

	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |=> s_axis_tready)
		else $error("input still stalled after output was taken");

endmodule

bind scalar_to_color_map cmap_checker u_cmap_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
